// ===== rtl/core/line_clip_rect_interp_top_defines.svh =====
// assertion macros used by the line clipper port checker
`ifndef LINE_CLIP_RECT_INTERP_TOP_DEFINES_SVH
`define LINE_CLIP_RECT_INTERP_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define LCR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line clipper check failed");

// next-cycle implication, active during reset too
`define LCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line clipper check failed");

`endif

// ===== rtl/core/lcr_pkg.sv =====
// shared types and constants for the line clipper
package lcr_pkg;

  localparam int CW             = 18;
  localparam int Q_BITS         = 17;
  localparam int QIW            = $clog2(Q_BITS);
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (Q_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  localparam int MODE_VERBOSE = 0;
  localparam int MODE_SHADE   = 1;
  localparam int MODE_DEPTH   = 2;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    crd_t               x;
    crd_t               y;
    logic signed [15:0] s;
    logic signed [31:0] z;
  } endpt_t;

  typedef struct packed {
    endpt_t     p;
    endpt_t     q;
    endpt_t     op;
    endpt_t     oq;
    logic [2:0] mode;
    logic       ylt;
    logic       in_rect;
    logic       rej;
    crd_t       left;
    crd_t       top;
    crd_t       right;
    crd_t       bottom;
  } item_t;

  typedef struct packed {
    logic axis_x;
    logic high_edge;
  } step_kind_t;

  localparam step_kind_t STEP_TOP    = '{axis_x: 1'b0, high_edge: 1'b0};
  localparam step_kind_t STEP_BOTTOM = '{axis_x: 1'b0, high_edge: 1'b1};
  localparam step_kind_t STEP_LEFT   = '{axis_x: 1'b1, high_edge: 1'b0};
  localparam step_kind_t STEP_RIGHT  = '{axis_x: 1'b1, high_edge: 1'b1};

  typedef enum logic [1:0] {
    ST_CLIPPED = 2'd0,
    ST_INSIDE  = 2'd1,
    ST_REJECT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_LEFT   = 2'd0,
    CFG_TOP    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_t;

endpackage

// ===== rtl/core/lcr_step.sv =====
// one pipelined clip step against a single rectangle edge
module lcr_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lcr_pkg::step_kind_t kind,
  input  logic               in_vld,
  input  lcr_pkg::item_t     in_item,
  output logic               out_vld,
  output lcr_pkg::item_t     out_item
);

  typedef struct packed {
    lcr_pkg::item_t     item;
    logic               clip;
    logic               a_is_q;
    logic [15:0]        den;
    logic               num0;
    logic [16:0]        rem;
    logic [16:0]        quo;
    logic signed [18:0] d_o;
    logic signed [16:0] d_s;
    logic signed [32:0] d_z;
  } div_t;

  typedef struct packed {
    lcr_pkg::item_t     item;
    logic               clip;
    logic               a_is_q;
    logic signed [36:0] prod_o;
    logic signed [34:0] prod_s;
    logic signed [50:0] prod_z;
  } mul_t;

  // setup
  lcr_pkg::endpt_t    ea, eb;
  lcr_pkg::crd_t      edge_c, ca, cb, oa, ob;
  logic signed [18:0] den_w, num_w;
  logic               a_is_q, active, cond, prerej, den_zero;
  div_t               setup_nxt, setup_r;
  logic               setup_vld_r;

  always_comb begin
    a_is_q = kind.axis_x | in_item.ylt;
    ea     = a_is_q ? in_item.q : in_item.p;
    eb     = a_is_q ? in_item.p : in_item.q;
    if (kind.axis_x) begin
      edge_c = kind.high_edge ? in_item.right : in_item.left;
      ca = ea.x;
      cb = eb.x;
      oa = ea.y;
      ob = eb.y;
    end else begin
      edge_c = kind.high_edge ? in_item.bottom : in_item.top;
      ca = ea.y;
      cb = eb.y;
      oa = ea.x;
      ob = eb.x;
    end
    active   = !in_item.in_rect && !in_item.rej;
    cond     = kind.high_edge ? (ca > edge_c) : (cb < edge_c);
    prerej   = kind.high_edge ? (cb > edge_c) : (ca < edge_c);
    den_w    = 19'(ca) - 19'(cb);
    num_w    = 19'(ca) - 19'(edge_c);
    den_zero = (den_w == '0);

    setup_nxt      = '0;
    setup_nxt.item = in_item;
    if (active && (prerej || (cond && den_zero))) begin
      setup_nxt.item.rej = 1'b1;
    end
    setup_nxt.clip   = active && cond && !prerej && !den_zero;
    setup_nxt.a_is_q = a_is_q;
    setup_nxt.den    = den_w[15:0];
    setup_nxt.num0   = num_w[0];
    setup_nxt.rem    = {2'b00, num_w[15:1]};
    setup_nxt.quo    = '0;
    setup_nxt.d_o    = 19'(oa) - 19'(ob);
    setup_nxt.d_s    = 17'(ea.s) - 17'(eb.s);
    setup_nxt.d_z    = 33'(ea.z) - 33'(eb.z);
  end

  // restoring divider, two quotient bits a stage, one in the last stage
  div_t div_in  [lcr_pkg::DIV_STAGES];
  div_t div_nxt [lcr_pkg::DIV_STAGES];
  div_t div_r   [lcr_pkg::DIV_STAGES];
  logic [lcr_pkg::DIV_STAGES-1:0] div_vld_r;

  always_comb begin
    div_in[0] = setup_r;
    for (int j = 1; j < lcr_pkg::DIV_STAGES; j++) begin
      div_in[j] = div_r[j-1];
    end
  end

  always_comb begin
    div_t        cur;
    logic [16:0] trial;
    int          k;
    for (int j = 0; j < lcr_pkg::DIV_STAGES; j++) begin
      cur = div_in[j];
      for (int t = 0; t < lcr_pkg::BITS_PER_STAGE; t++) begin
        k = lcr_pkg::Q_BITS - 1 - j * lcr_pkg::BITS_PER_STAGE - t;
        if (k >= 0) begin
          trial = {cur.rem[15:0], (k == lcr_pkg::Q_BITS - 1) ? cur.num0 : 1'b0};
          if (trial >= {1'b0, cur.den}) begin
            cur.rem = trial - {1'b0, cur.den};
            cur.quo[lcr_pkg::QIW'(k)] = 1'b1;
          end else begin
            cur.rem = trial;
          end
        end
      end
      div_nxt[j] = cur;
    end
  end

  // multiply differences by the ratio
  div_t               dlast;
  logic signed [17:0] sq;
  mul_t               mul_nxt, mul_r;
  logic               mul_vld_r;

  always_comb begin
    dlast          = div_r[lcr_pkg::DIV_STAGES-1];
    sq             = $signed({1'b0, dlast.quo});
    mul_nxt.item   = dlast.item;
    mul_nxt.clip   = dlast.clip;
    mul_nxt.a_is_q = dlast.a_is_q;
    mul_nxt.prod_o = 37'(dlast.d_o) * 37'(sq);
    mul_nxt.prod_s = 35'(dlast.d_s) * 35'(sq);
    mul_nxt.prod_z = 51'(dlast.d_z) * 51'(sq);
  end

  // anchor minus scaled difference, edge written on the clipped axis
  lcr_pkg::endpt_t    fa, fm;
  lcr_pkg::crd_t      f_edge, f_oa;
  logic               m_is_q;
  logic signed [36:0] t_o;
  logic signed [34:0] t_s;
  logic signed [50:0] t_z;
  lcr_pkg::item_t     fin_nxt, fin_r;
  logic               fin_vld_r;

  always_comb begin
    fa     = mul_r.a_is_q ? mul_r.item.q : mul_r.item.p;
    m_is_q = kind.high_edge ? mul_r.a_is_q : !mul_r.a_is_q;
    fm     = m_is_q ? mul_r.item.q : mul_r.item.p;
    if (kind.axis_x) begin
      f_edge = kind.high_edge ? mul_r.item.right : mul_r.item.left;
      f_oa   = fa.y;
    end else begin
      f_edge = kind.high_edge ? mul_r.item.bottom : mul_r.item.top;
      f_oa   = fa.x;
    end
    t_o = 37'(f_oa) - (mul_r.prod_o >>> 16);
    t_s = 35'(fa.s) - (mul_r.prod_s >>> 16);
    t_z = 51'(fa.z) - (mul_r.prod_z >>> 16);
    if (kind.axis_x) begin
      fm.x = f_edge;
      fm.y = t_o[17:0];
    end else begin
      fm.y = f_edge;
      fm.x = t_o[17:0];
    end
    if (mul_r.item.mode[lcr_pkg::MODE_SHADE]) begin
      fm.s = t_s[15:0];
    end
    if (mul_r.item.mode[lcr_pkg::MODE_DEPTH]) begin
      fm.z = t_z[31:0];
    end
    fin_nxt = mul_r.item;
    if (mul_r.clip) begin
      if (m_is_q) begin
        fin_nxt.q = fm;
      end else begin
        fin_nxt.p = fm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_vld_r <= 1'b0;
      div_vld_r   <= '0;
      mul_vld_r   <= 1'b0;
      fin_vld_r   <= 1'b0;
    end else if (adv) begin
      setup_vld_r <= in_vld;
      div_vld_r   <= {div_vld_r[lcr_pkg::DIV_STAGES-2:0], setup_vld_r};
      mul_vld_r   <= div_vld_r[lcr_pkg::DIV_STAGES-1];
      fin_vld_r   <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      setup_r <= setup_nxt;
      for (int j = 0; j < lcr_pkg::DIV_STAGES; j++) begin
        div_r[j] <= div_nxt[j];
      end
      mul_r <= mul_nxt;
      fin_r <= fin_nxt;
    end
  end

  assign out_vld  = fin_vld_r;
  assign out_item = fin_r;

endmodule

// ===== rtl/core/line_clip_rect_interp_top.sv =====
// line segment clipper to a rectangle with shade and depth interpolation, top level
// 51 register stages from the input register to the output register
// one segment per cycle while the pipe is not held; each edge step has a 9-stage divider and a multiply stage
// the whole pipe holds only while a finished result waits on out_stall
// reset: synchronous active-low rst_n clears all valid bits and loads the default rectangle
module line_clip_rect_interp_top (
  input  logic               clk,
  input  logic               rst_n,
  // segment requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_shade,
  input  logic signed [31:0] in_first_depth,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_shade,
  input  logic signed [31:0] in_second_depth,
  input  logic [2:0]         in_mode_bits,
  // clipped segments
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_left_x,
  output logic signed [15:0] out_left_y,
  output logic signed [15:0] out_left_shade,
  output logic signed [31:0] out_left_depth,
  output logic signed [15:0] out_right_x,
  output logic signed [15:0] out_right_y,
  output logic signed [15:0] out_right_shade,
  output logic signed [31:0] out_right_depth,
  // rectangle registers
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // output request valid
  logic out_valid_r;

  // global advance: every stage moves unless the output holds a stalled result
  logic adv;
  assign adv       = !(out_valid_r && out_stall);
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  // rectangle registers; writing them only while the pipe is empty is up to the user, the block does not enforce it
  logic signed [15:0] clip_left_r, clip_top_r;
  logic [15:0]        clip_width_r, clip_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= 16'sd0;
      clip_top_r    <= 16'sd0;
      clip_width_r  <= 16'd640;
      clip_height_r <= 16'd480;
    end else if (cfg_valid) begin
      case (lcr_pkg::cfg_idx_t'(cfg_index))
        lcr_pkg::CFG_LEFT:   clip_left_r   <= $signed(cfg_data);
        lcr_pkg::CFG_TOP:    clip_top_r    <= $signed(cfg_data);
        lcr_pkg::CFG_WIDTH:  clip_width_r  <= cfg_data;
        lcr_pkg::CFG_HEIGHT: clip_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // edges, right and bottom without wrap
  lcr_pkg::crd_t e_left, e_top, e_right, e_bottom;
  assign e_left   = 18'(clip_left_r);
  assign e_top    = 18'(clip_top_r);
  assign e_right  = 18'(clip_left_r) + $signed({2'b00, clip_width_r});
  assign e_bottom = 18'(clip_top_r) + $signed({2'b00, clip_height_r});

  // input register stage
  lcr_pkg::endpt_t ina_r, inb_r;
  logic [2:0]      inmode_r;
  logic            in_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ina_r.x  <= 18'(in_first_x);
      ina_r.y  <= 18'(in_first_y);
      ina_r.s  <= in_first_shade;
      ina_r.z  <= in_first_depth;
      inb_r.x  <= 18'(in_second_x);
      inb_r.y  <= 18'(in_second_y);
      inb_r.s  <= in_second_shade;
      inb_r.z  <= in_second_depth;
      inmode_r <= in_mode_bits;
    end
  end

  // order by x (first wins a tie), inside test, first trivial reject
  lcr_pkg::endpt_t pp, pq;
  lcr_pkg::item_t  pre_nxt;
  logic            a_in, b_in;

  always_comb begin
    if (ina_r.x > inb_r.x) begin
      pp = inb_r;
      pq = ina_r;
    end else begin
      pp = ina_r;
      pq = inb_r;
    end
    a_in = (ina_r.x >= e_left) && (ina_r.x < e_right) &&
           (ina_r.y >= e_top) && (ina_r.y < e_bottom);
    b_in = (inb_r.x >= e_left) && (inb_r.x < e_right) &&
           (inb_r.y >= e_top) && (inb_r.y < e_bottom);
    pre_nxt.p       = pp;
    pre_nxt.q       = pq;
    pre_nxt.op      = pp;
    pre_nxt.oq      = pq;
    pre_nxt.mode    = inmode_r;
    pre_nxt.ylt     = pp.y < pq.y;
    pre_nxt.in_rect = a_in && b_in;
    pre_nxt.rej     = !(a_in && b_in) && ((pq.x < e_left) || (pp.x > e_right));
    pre_nxt.left    = e_left;
    pre_nxt.top     = e_top;
    pre_nxt.right   = e_right;
    pre_nxt.bottom  = e_bottom;
  end

  logic           stg_vld  [5];
  lcr_pkg::item_t stg_item [5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld[0] <= 1'b0;
    end else if (adv) begin
      stg_vld[0] <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_item[0] <= pre_nxt;
    end
  end

  // edge steps: top, bottom, left, right, in the order the clip needs
  lcr_step u_step_top (
    .clk(clk), .rst_n(rst_n), .adv(adv), .kind(lcr_pkg::STEP_TOP),
    .in_vld(stg_vld[0]), .in_item(stg_item[0]),
    .out_vld(stg_vld[1]), .out_item(stg_item[1])
  );

  lcr_step u_step_bottom (
    .clk(clk), .rst_n(rst_n), .adv(adv), .kind(lcr_pkg::STEP_BOTTOM),
    .in_vld(stg_vld[1]), .in_item(stg_item[1]),
    .out_vld(stg_vld[2]), .out_item(stg_item[2])
  );

  lcr_step u_step_left (
    .clk(clk), .rst_n(rst_n), .adv(adv), .kind(lcr_pkg::STEP_LEFT),
    .in_vld(stg_vld[2]), .in_item(stg_item[2]),
    .out_vld(stg_vld[3]), .out_item(stg_item[3])
  );

  lcr_step u_step_right (
    .clk(clk), .rst_n(rst_n), .adv(adv), .kind(lcr_pkg::STEP_RIGHT),
    .in_vld(stg_vld[3]), .in_item(stg_item[3]),
    .out_vld(stg_vld[4]), .out_item(stg_item[4])
  );

  // final reject test and result selection
  lcr_pkg::item_t   fi;
  lcr_pkg::endpt_t  rl, rr;
  lcr_pkg::status_t st;
  logic             fail;

  always_comb begin
    fi   = stg_item[4];
    fail = (fi.p.x >= fi.right) || (fi.q.x < fi.left) ||
           ((fi.p.y >= fi.bottom) && (fi.q.y >= fi.bottom)) ||
           ((fi.p.y < fi.top) && (fi.q.y < fi.top));
    if (fi.in_rect) begin
      st = fi.mode[lcr_pkg::MODE_VERBOSE] ? lcr_pkg::ST_INSIDE : lcr_pkg::ST_CLIPPED;
      rl = fi.op;
      rr = fi.oq;
    end else if (fi.rej || fail) begin
      // rejected segments carry the ordered input endpoints
      st = lcr_pkg::ST_REJECT;
      rl = fi.op;
      rr = fi.oq;
    end else begin
      st = lcr_pkg::ST_CLIPPED;
      rl = fi.p;
      rr = fi.q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status      <= st;
      out_left_x      <= rl.x[15:0];
      out_left_y      <= rl.y[15:0];
      out_left_shade  <= rl.s;
      out_left_depth  <= rl.z;
      out_right_x     <= rr.x[15:0];
      out_right_y     <= rr.y[15:0];
      out_right_shade <= rr.s;
      out_right_depth <= rr.z;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/lcr_checker.sv =====
// port-level checker for the line clipper and its bind
`include "line_clip_rect_interp_top_defines.svh"

module lcr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [15:0] out_left_x,
  input logic signed [15:0] out_right_x
);

  `LCR_ASSERT_NEXT(a_reset_clears, !rst_n, !out_valid)
  `LCR_ASSERT_IMPL(a_stall_only_when_held, in_stall, out_valid && out_stall)
  `LCR_ASSERT_IMPL(a_left_to_right, out_valid, out_left_x <= out_right_x)
  `LCR_ASSERT_IMPL(a_status_code, out_valid, out_status != 2'd3)

endmodule

bind line_clip_rect_interp_top lcr_checker u_lcr_checker (.*);

// ===== verif/lcr_clip_checker.sv =====
// segment clip checker: watches the channels, predicts clipped segments and compares
`timescale 1ns / 100ps
module lcr_clip_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_shade,
  input  logic signed [31:0] in_first_depth,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_shade,
  input  logic signed [31:0] in_second_depth,
  input  logic [2:0]         in_mode_bits,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_status,
  input  logic signed [15:0] out_left_x,
  input  logic signed [15:0] out_left_y,
  input  logic signed [15:0] out_left_shade,
  input  logic signed [31:0] out_left_depth,
  input  logic signed [15:0] out_right_x,
  input  logic signed [15:0] out_right_y,
  input  logic signed [15:0] out_right_shade,
  input  logic signed [31:0] out_right_depth,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 segs_waiting
);

  typedef struct {
    longint x, y, s, z;
  } vtx_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [15:0] lx, ly, ls;
    logic [31:0] lz;
    logic [15:0] rx, ry, rs;
    logic [31:0] rz;
  } seg_res_t;

  longint   rect_left, rect_top, rect_width, rect_height;
  seg_res_t clipped_q[$];

  function automatic longint blend(longint a, longint b, longint f);
    return a - (((a - b) * f) >>> 16);
  endfunction

  function automatic void carry_attrs(inout vtx_t m, input vtx_t a, input vtx_t b,
                                      input longint f, input logic [2:0] mode);
    if (mode[lcr_pkg::MODE_SHADE]) m.s = blend(a.s, b.s, f);
    if (mode[lcr_pkg::MODE_DEPTH]) m.z = blend(a.z, b.z, f);
  endfunction

  // false when the segment is rejected; p is the left endpoint
  function automatic bit clip_span(inout vtx_t p, inout vtx_t q, input logic [2:0] mode);
    longint tp, bt, lf, rt, f;
    tp = rect_top;
    bt = rect_top + rect_height;
    lf = rect_left;
    rt = rect_left + rect_width;
    if (q.x < lf || p.x > rt) return 0;
    if (p.y < q.y) begin
      if (q.y < tp || p.y > bt) return 0;
      if (p.y < tp) begin
        if (q.y == p.y) return 0;
        f = ((q.y - tp) * 65536) / (q.y - p.y);
        p.x = blend(q.x, p.x, f);
        p.y = tp;
        carry_attrs(p, q, p, f, mode);
      end
      if (q.y > bt) begin
        if (q.y == p.y) return 0;
        f = ((q.y - bt) * 65536) / (q.y - p.y);
        q.x = blend(q.x, p.x, f);
        q.y = bt;
        carry_attrs(q, q, p, f, mode);
      end
    end else begin
      if (p.y < tp || q.y > bt) return 0;
      if (q.y < tp) begin
        if (p.y == q.y) return 0;
        f = ((p.y - tp) * 65536) / (p.y - q.y);
        q.x = blend(p.x, q.x, f);
        q.y = tp;
        carry_attrs(q, p, q, f, mode);
      end
      if (p.y > bt) begin
        if (p.y == q.y) return 0;
        f = ((p.y - bt) * 65536) / (p.y - q.y);
        p.x = blend(p.x, q.x, f);
        p.y = bt;
        carry_attrs(p, p, q, f, mode);
      end
    end
    if (p.x < lf) begin
      if (q.x < lf || q.x == p.x) return 0;
      f = ((q.x - lf) * 65536) / (q.x - p.x);
      p.y = blend(q.y, p.y, f);
      p.x = lf;
      carry_attrs(p, q, p, f, mode);
    end
    if (q.x > rt) begin
      if (p.x > rt || q.x == p.x) return 0;
      f = ((q.x - rt) * 65536) / (q.x - p.x);
      q.y = blend(q.y, p.y, f);
      q.x = rt;
      carry_attrs(q, q, p, f, mode);
    end
    if (p.x >= rt || q.x < lf || (p.y >= bt && q.y >= bt) || (p.y < tp && q.y < tp))
      return 0;
    return 1;
  endfunction

  function automatic seg_res_t pack_seg(lcr_pkg::status_t st, vtx_t p, vtx_t q);
    seg_res_t r;
    r.st = st;
    r.lx = p.x[15:0]; r.ly = p.y[15:0]; r.ls = p.s[15:0]; r.lz = p.z[31:0];
    r.rx = q.x[15:0]; r.ry = q.y[15:0]; r.rs = q.s[15:0]; r.rz = q.z[31:0];
    return r;
  endfunction

  function automatic seg_res_t predict_clip();
    vtx_t             a, b, p, q, cp, cq;
    bit               in_a, in_b;
    lcr_pkg::status_t st;
    a.x = in_first_x;  a.y = in_first_y;  a.s = in_first_shade;  a.z = in_first_depth;
    b.x = in_second_x; b.y = in_second_y; b.s = in_second_shade; b.z = in_second_depth;
    if (a.x > b.x) begin p = b; q = a; end
    else begin p = a; q = b; end
    in_a = a.x >= rect_left && a.x < rect_left + rect_width &&
           a.y >= rect_top && a.y < rect_top + rect_height;
    in_b = b.x >= rect_left && b.x < rect_left + rect_width &&
           b.y >= rect_top && b.y < rect_top + rect_height;
    if (in_a && in_b) begin
      st = in_mode_bits[lcr_pkg::MODE_VERBOSE] ? lcr_pkg::ST_INSIDE : lcr_pkg::ST_CLIPPED;
      return pack_seg(st, p, q);
    end
    cp = p;
    cq = q;
    if (clip_span(cp, cq, in_mode_bits)) return pack_seg(lcr_pkg::ST_CLIPPED, cp, cq);
    return pack_seg(lcr_pkg::ST_REJECT, p, q);
  endfunction

  always @(posedge clk) begin
    seg_res_t got, want;
    if (!rst_n) begin
      rect_left    <= 0;
      rect_top     <= 0;
      rect_width   <= 640;
      rect_height  <= 480;
      mismatches   <= 0;
      segs_waiting <= 0;
      clipped_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lcr_pkg::cfg_idx_t'(cfg_index))
          lcr_pkg::CFG_LEFT:   rect_left   <= longint'($signed(cfg_data));
          lcr_pkg::CFG_TOP:    rect_top    <= longint'($signed(cfg_data));
          lcr_pkg::CFG_WIDTH:  rect_width  <= longint'(cfg_data);
          lcr_pkg::CFG_HEIGHT: rect_height <= longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) clipped_q.push_back(predict_clip());
      if (out_valid && !out_stall) begin
        got = '{out_status, out_left_x, out_left_y, out_left_shade, out_left_depth,
                out_right_x, out_right_y, out_right_shade, out_right_depth};
        if (clipped_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("%0t: unexpected segment %h", $realtime, got);
        end else begin
          want = clipped_q.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"%0t: segment mismatch\n",
                        "  exp st=%0d L=(%0d,%0d,%0d,%0d) R=(%0d,%0d,%0d,%0d)\n",
                        "  got st=%0d L=(%0d,%0d,%0d,%0d) R=(%0d,%0d,%0d,%0d)"},
                       $realtime, want.st, $signed(want.lx), $signed(want.ly),
                       $signed(want.ls), $signed(want.lz), $signed(want.rx),
                       $signed(want.ry), $signed(want.rs), $signed(want.rz),
                       got.st, $signed(got.lx), $signed(got.ly), $signed(got.ls),
                       $signed(got.lz), $signed(got.rx), $signed(got.ry),
                       $signed(got.rs), $signed(got.rz));
          end
        end
      end
      segs_waiting <= clipped_q.size();
    end
  end

endmodule

// ===== verif/tb_line_clip_rect_interp_top.sv =====
// testbench top for the line clipper: stimulus, stall control and verdict
`timescale 1ns / 100ps
module tb_line_clip_rect_interp_top;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_first_x = '0, in_first_y = '0, in_first_shade = '0;
  logic signed [31:0] in_first_depth = '0;
  logic signed [15:0] in_second_x = '0, in_second_y = '0, in_second_shade = '0;
  logic signed [31:0] in_second_depth = '0;
  logic [2:0]         in_mode_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [15:0] out_left_x, out_left_y, out_left_shade;
  logic signed [31:0] out_left_depth;
  logic signed [15:0] out_right_x, out_right_y, out_right_shade;
  logic signed [31:0] out_right_depth;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  int mismatches, segs_waiting;
  // handshake flags of the last rising edge, read at the falling edge
  logic in_took = 1'b0, cfg_took = 1'b0;
  bit   no_idle = 1'b0;    // stretch with no idling on either side
  bit   hold_go = 1'b0;    // asks the stall process for its long hold-off
  bit   hold_used = 1'b0;  // hold-off already started
  int   hold_cycles = 0;   // long receiver hold-off, counted down by the stall process
  int   segs_sent = 0;
  // current rectangle, mirrored here only to aim random segments at it
  int   aim_left = 0, aim_top = 0, aim_w = 640, aim_h = 480;

  line_clip_rect_interp_top dut (.*);

  lcr_clip_checker chk (.*);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    in_took  <= in_valid && !in_stall;
    cfg_took <= cfg_valid && cfg_ready;
  end

  // receiver side: random stalls, a quiet stretch and one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_go && !hold_used) begin
      out_stall <= 1'b1;
      hold_cycles <= 299;
      hold_used <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 28);
    end
  end

  // give up after a generous fixed time
  initial begin
    #2000000;
    $display("tb_line_clip_rect_interp_top: done, errors");
    $finish;
  end

  // one segment request, entered and left at a falling edge
  task automatic send_seg(input int ax, ay, ash, input logic [31:0] az,
                          input int bx, by, bsh, input logic [31:0] bz,
                          input logic [2:0] mode);
    // random gap before the request
    if (!no_idle && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_first_x  <= ax[15:0]; in_first_y  <= ay[15:0];
    in_first_shade <= ash[15:0]; in_first_depth <= az;
    in_second_x <= bx[15:0]; in_second_y <= by[15:0];
    in_second_shade <= bsh[15:0]; in_second_depth <= bz;
    in_mode_bits <= mode;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_took);
    segs_sent++;
  endtask

  // register write while the pipe is empty; the caller drops cfg_valid
  task automatic write_reg(input lcr_pkg::cfg_idx_t idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (segs_waiting != 0) @(negedge clk);
    // pipe is 51 stages deep
    repeat (60) @(negedge clk);
  endtask

  task automatic set_rect(input int l, t, w, h);
    drain();
    write_reg(lcr_pkg::CFG_LEFT, l[15:0]);
    write_reg(lcr_pkg::CFG_TOP, t[15:0]);
    write_reg(lcr_pkg::CFG_WIDTH, w[15:0]);
    write_reg(lcr_pkg::CFG_HEIGHT, h[15:0]);
    cfg_valid <= 1'b0;
    aim_left = $signed(l[15:0]);
    aim_top  = $signed(t[15:0]);
    aim_w    = w[15:0];
    aim_h    = h[15:0];
  endtask

  // coordinate near the span [lo, lo+len], sometimes anywhere
  function automatic int pick(int lo, int len);
    int v;
    if ($urandom_range(99) < 15) return $signed(16'($urandom));
    v = lo + $urandom_range(len + 80) - 40;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic random_segs(int n);
    for (int i = 0; i < n; i++)
      send_seg(pick(aim_left, aim_w), pick(aim_top, aim_h), $signed(16'($urandom)),
               $urandom, pick(aim_left, aim_w), pick(aim_top, aim_h),
               $signed(16'($urandom)), $urandom, 3'($urandom));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed segments against the default 640x480 rectangle
    send_seg(10, 20, 100, 32'h7fffffff, 600, 400, -5, 32'h80000000, 3'd1); // inside, verbose
    send_seg(600, 400, 3, 5, 10, 20, 7, 9, 3'd0);                          // inside, swapped
    send_seg(-50, 10, 0, 0, -1, 400, 0, 0, 3'd7);                          // left of rect
    send_seg(700, 10, 0, 0, 900, 400, 0, 0, 3'd7);                         // right of rect
    send_seg(10, -30, 0, 0, 500, -1, 0, 0, 3'd7);                          // above
    send_seg(10, 500, 0, 0, 500, 700, 0, 0, 3'd7);                         // below
    send_seg(100, -100, 32767, 32'h7fffffff, 200, 100, -32768, 32'h80000000, 3'd6);
    send_seg(100, 100, 1000, 1000, 200, 900, -1000, -1000, 3'd2);          // bottom crossing
    send_seg(-100, 50, 500, 0, 300, 60, -500, 4000, 3'd4);                 // left crossing
    send_seg(300, 50, 5, 100, 1000, 300, 500, -100, 3'd6);                 // right crossing
    send_seg(-200, -200, -32768, 32'h80000000, 900, 700, 32767, 32'h7fffffff, 3'd7);
    send_seg(900, -10, 1, 2, -100, 600, 3, 4, 3'd3);                       // diagonal, swapped
    send_seg(320, -100, 9, 9, 320, 900, -9, -9, 3'd7);                     // vertical line
    send_seg(-100, 240, 9, 9, 900, 240, -9, -9, 3'd7);                     // horizontal line
    send_seg(-32768, -32768, 0, 0, 32767, 32767, 100, 100, 3'd5);          // field extremes
    send_seg(32767, -32768, -1, -1, -32768, 32767, 1, 1, 3'd7);
    send_seg(640, 480, 0, 0, 640, 480, 0, 0, 3'd1);                        // on far corner
    send_seg(0, 0, 0, 0, 639, 479, 0, 0, 3'd1);                            // exact bounds

    random_segs(60);
    // long receiver hold-off while the sender keeps offering
    no_idle = 1'b1;
    hold_go = 1'b1;
    random_segs(70);
    no_idle = 1'b0;
    // sender pause until every segment is back
    in_valid <= 1'b0;
    while (segs_waiting != 0) @(negedge clk);
    random_segs(20);

    set_rect(-100, -50, 300, 200);
    random_segs(80);
    set_rect(-32768, -32768, 65535, 65535);
    send_seg(-32768, -32768, 1, 1, 32767, 32767, 2, 2, 3'd1);
    random_segs(60);
    set_rect(32767, 32767, 0, 0);                          // degenerate, far corner
    random_segs(40);
    set_rect(100, 100, 0, 50);                             // zero width
    random_segs(40);
    set_rect(-20, 30, 64, 1);                              // one-row rectangle
    random_segs(80);

    drain();
    $display("covered %0d segments over 6 rectangles, incl. degenerate and full-range ones",
             segs_sent);
    if (mismatches == 0)
      $display("tb_line_clip_rect_interp_top: done, clean");
    else
      $display("tb_line_clip_rect_interp_top: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lcr_pkg.sv
rtl/core/lcr_step.sv
rtl/core/line_clip_rect_interp_top.sv
rtl/core/lcr_checker.sv
verif/lcr_clip_checker.sv
verif/tb_line_clip_rect_interp_top.sv
